/* sv/lsp_pkg.sv */
// shared types, constants and tables for the langevin particle step block
// no dependencies; imported by the top level, lsp_mul and lsp_cordic

package lsp_pkg;

	// default sizes handed to the top level parameters, and the configuration index width
	localparam int STATE_WIDTH_DEF  = 48;
	localparam int UNIFORM_BITS_DEF = 16;
	localparam int CFG_IDX_W        = 3;

	// fixed point constants of the noise path
	localparam int          CORDIC_STEPS = 24;
	localparam int          LOG_BITS     = 30;
	localparam logic [33:0] CORDIC_GAIN  = 34'd652032874;
	localparam logic [31:0] TWO_LN2_Q28  = 32'd372130559;
	localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;

	// reset values of the configuration registers
	localparam logic [31:0] DAMPING_RST  = 32'd42950;
	localparam logic [23:0] INV_MASS_RST = 24'd655360;
	localparam logic [15:0] DT_RST       = 16'd256;
	localparam logic [63:0] START_POS_RST = 64'd6553600;
	localparam logic [63:0] START_VEL_RST = 64'd6554;

	// right shift applied after a multiplication
	typedef enum logic [2:0] {
		SH_8,
		SH_16,
		SH_30,
		SH_31,
		SH_32,
		SH_42
	} lsp_sh_t;

	// arctangent of 2^-i in Q.30
	function automatic logic [29:0] lsp_atan(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:    v = 30'd843314857;
			5'd1:    v = 30'd497837829;
			5'd2:    v = 30'd263043837;
			5'd3:    v = 30'd133525159;
			5'd4:    v = 30'd67021687;
			5'd5:    v = 30'd33543516;
			5'd6:    v = 30'd16775851;
			5'd7:    v = 30'd8388437;
			5'd8:    v = 30'd4194283;
			5'd9:    v = 30'd2097149;
			5'd10:   v = 30'd1048575;
			5'd11:   v = 30'd524287;
			5'd12:   v = 30'd262143;
			5'd13:   v = 30'd131071;
			5'd14:   v = 30'd65535;
			5'd15:   v = 30'd32767;
			5'd16:   v = 30'd16383;
			5'd17:   v = 30'd8191;
			5'd18:   v = 30'd4095;
			5'd19:   v = 30'd2047;
			5'd20:   v = 30'd1023;
			5'd21:   v = 30'd511;
			5'd22:   v = 30'd255;
			5'd23:   v = 30'd127;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

/* sv/langevin_particle_step.sv */
// top level of the langevin particle step: sequencer, state and config registers
// uses lsp_pkg, lsp_mul, lsp_isqrt and lsp_cordic

// One transaction in gives one transaction out: a Box-Muller Gaussian pair is made
// from the two uniform codes and drives one Euler step of the 2-D particle state.
// Most of the time of an item goes to the shared multiplier, which is passed
// 42 times (30 squarings for the logarithm, four for the noise pair, eight for the
// two axis updates), besides the normalisation, the square root and the cordic.
// in_ready is high only between items; a finished result waits in its own output
// register, so the next item is taken while it is still unclaimed. Configuration
// is to be written through cfg_we/cfg_index/cfg_data between items; the block
// itself does not enforce this. Unknown indexes are ignored.

module langevin_particle_step #(
	parameter int STATE_WIDTH  = lsp_pkg::STATE_WIDTH_DEF,
	parameter int UNIFORM_BITS = lsp_pkg::UNIFORM_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [lsp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [((STATE_WIDTH > 32) ? STATE_WIDTH : 32)-1:0] cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [UNIFORM_BITS-1:0]               uniform_a,
	input  logic [UNIFORM_BITS-1:0]               uniform_b,
	input  logic                                  restart,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [STATE_WIDTH-1:0]         pos_x,
	output logic signed [STATE_WIDTH-1:0]         pos_y,
	output logic signed [STATE_WIDTH-1:0]         vel_x,
	output logic signed [STATE_WIDTH-1:0]         vel_y,
	output logic                                  saturated
);
	import lsp_pkg::*;

	localparam int SW = STATE_WIDTH;
	localparam int EW = $clog2(UNIFORM_BITS + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DAMPING,
		CFG_INV_MASS,
		CFG_TIME_STEP,
		CFG_START_PX,
		CFG_START_PY,
		CFG_START_VX,
		CFG_START_VY
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_NORM, S_MUL, S_MWAIT, S_SQRT, S_SWAIT, S_CORDIC, S_CWAIT, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_LOG, OP_R2, OP_ANG, OP_G0, OP_G1, OP_DAMP, OP_ACC, OP_DV, OP_POS
	} op_t;

	typedef struct packed {
		logic signed [63:0] v;
		logic               clip;
	} sat64_t;

	typedef struct packed {
		logic signed [SW-1:0] v;
		logic                 clip;
	} satst_t;

	// configuration registers
	logic [31:0]           damping_q;
	logic [23:0]           inv_mass_q;
	logic [15:0]           time_step_q;
	logic signed [SW-1:0]  start_px_q;
	logic signed [SW-1:0]  start_py_q;
	logic signed [SW-1:0]  start_vx_q;
	logic signed [SW-1:0]  start_vy_q;

	// particle state
	logic signed [SW-1:0]  pos_x_q;
	logic signed [SW-1:0]  pos_y_q;
	logic signed [SW-1:0]  vel_x_q;
	logic signed [SW-1:0]  vel_y_q;

	// output register
	logic signed [SW-1:0]  out_px_q;
	logic signed [SW-1:0]  out_py_q;
	logic signed [SW-1:0]  out_vx_q;
	logic signed [SW-1:0]  out_vy_q;
	logic                  out_sat_q;
	logic                  out_valid_q;

	// sequencer and work registers
	state_t                state_q;
	op_t                   step_q;
	logic                  axis_q;
	logic [UNIFORM_BITS-1:0] b_q;
	logic [32:0]           x_q;
	logic [EW-1:0]         e_q;
	logic [LOG_BITS-1:0]   f_q;
	logic [4:0]            i_q;
	logic [63:0]           sqrt_v_q;
	logic [31:0]           r_q;
	logic signed [33:0]    z_q;
	logic signed [33:0]    c_q;
	logic signed [33:0]    s_q;
	logic signed [63:0]    g0_q;
	logic signed [63:0]    g1_q;
	logic signed [63:0]    w_q;
	logic                  clip_q;

	// shared unit connections
	logic                  mul_start;
	logic signed [63:0]    mul_a;
	logic [31:0]           mul_b;
	lsp_sh_t               mul_sh;
	logic                  mul_done;
	logic signed [63:0]    mul_res;
	logic                  mul_clip;
	logic                  sqrt_done;
	logic [31:0]           sqrt_root;
	logic                  cor_done;
	logic signed [33:0]    cor_cos;
	logic signed [33:0]    cor_sin;

	logic [UNIFORM_BITS:0] m_w;
	logic [32:0]           xs_w;
	logic [63:0]           t_w;
	logic [31:0]           ang_w;
	logic signed [SW-1:0]  v_sel;
	logic signed [SW-1:0]  p_sel;
	logic signed [63:0]    g_sel;
	sat64_t                upd_a;
	satst_t                upd_s;

	// saturating 64 bit add or subtract
	function automatic sat64_t add_sat64(input logic signed [63:0] a,
			input logic signed [63:0] b, input logic sub);
		logic signed [64:0] s;
		sat64_t             r;
		s = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
		r.clip = s[64] ^ s[63];
		if (r.clip) begin
			r.v = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			r.v = s[63:0];
		end
		return r;
	endfunction

	// clip a 64 bit value into the state width
	function automatic satst_t sat_state(input logic signed [63:0] v);
		satst_t r;
		logic   fits;
		fits = (&v[63:SW-1]) | ~(|v[63:SW-1]);
		r.clip = ~fits;
		if (fits) begin
			r.v = v[SW-1:0];
		end else begin
			r.v = v[63] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end
		return r;
	endfunction

	// input decoding for the log normalisation and the angle
	assign m_w   = {1'b0, uniform_a} + (UNIFORM_BITS + 1)'(1);
	assign xs_w  = 33'(m_w) << (32 - UNIFORM_BITS);
	assign t_w   = ((64'(UNIFORM_BITS) - 64'(e_q)) << 30) - 64'(f_q);
	assign ang_w = 32'(b_q) << (32 - UNIFORM_BITS);

	assign v_sel = axis_q ? vel_y_q : vel_x_q;
	assign p_sel = axis_q ? pos_y_q : pos_x_q;
	assign g_sel = axis_q ? g1_q : g0_q;

	// multiplier operand selection by step
	always_comb begin
		case (step_q)
			OP_LOG: begin
				mul_a  = 64'(x_q[31:0]);
				mul_b  = x_q[31:0];
				mul_sh = SH_31;
			end
			OP_R2: begin
				mul_a  = signed'(t_w);
				mul_b  = TWO_LN2_Q28;
				mul_sh = SH_30;
			end
			OP_ANG: begin
				mul_a  = 64'(ang_w[29:0]);
				mul_b  = TWO_PI_Q29;
				mul_sh = SH_31;
			end
			OP_G0: begin
				mul_a  = 64'(c_q);
				mul_b  = r_q;
				mul_sh = SH_42;
			end
			OP_G1: begin
				mul_a  = 64'(s_q);
				mul_b  = r_q;
				mul_sh = SH_42;
			end
			OP_DAMP: begin
				mul_a  = 64'(v_sel);
				mul_b  = damping_q;
				mul_sh = SH_32;
			end
			OP_ACC: begin
				mul_a  = w_q;
				mul_b  = 32'(inv_mass_q);
				mul_sh = SH_16;
			end
			OP_DV: begin
				mul_a  = w_q;
				mul_b  = 32'(time_step_q);
				mul_sh = SH_8;
			end
			OP_POS: begin
				mul_a  = 64'(v_sel);
				mul_b  = 32'(time_step_q);
				mul_sh = SH_8;
			end
			default: begin
				mul_a  = '0;
				mul_b  = '0;
				mul_sh = SH_8;
			end
		endcase
	end

	// saturating update after the axis multiplies
	always_comb begin
		case (step_q)
			OP_DAMP: upd_a = add_sat64(g_sel, mul_res, 1'b1);
			OP_DV:   upd_a = add_sat64(64'(v_sel), mul_res, 1'b0);
			default: upd_a = add_sat64(64'(p_sel), mul_res, 1'b0);
		endcase
		upd_s = sat_state(upd_a.v);
	end

	assign mul_start = (state_q == S_MUL);

	lsp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.sh     (mul_sh),
		.done   (mul_done),
		.res    (mul_res),
		.clip   (mul_clip)
	);

	lsp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_SQRT),
		.v      (sqrt_v_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	lsp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_CORDIC),
		.z0     (z_q),
		.quad   (ang_w[31:30]),
		.done   (cor_done),
		.cos_o  (cor_cos),
		.sin_o  (cor_sin)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damping_q   <= DAMPING_RST;
			inv_mass_q  <= INV_MASS_RST;
			time_step_q <= DT_RST;
			start_px_q  <= START_POS_RST[SW-1:0];
			start_py_q  <= START_POS_RST[SW-1:0];
			start_vx_q  <= START_VEL_RST[SW-1:0];
			start_vy_q  <= START_VEL_RST[SW-1:0];
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DAMPING:   damping_q   <= cfg_data[31:0];
				CFG_INV_MASS:  inv_mass_q  <= cfg_data[23:0];
				CFG_TIME_STEP: time_step_q <= cfg_data[15:0];
				CFG_START_PX:  start_px_q  <= cfg_data[SW-1:0];
				CFG_START_PY:  start_py_q  <= cfg_data[SW-1:0];
				CFG_START_VX:  start_vx_q  <= cfg_data[SW-1:0];
				CFG_START_VY:  start_vy_q  <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// main sequencer, particle state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= OP_LOG;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
			clip_q      <= 1'b0;
			i_q         <= '0;
			pos_x_q     <= START_POS_RST[SW-1:0];
			pos_y_q     <= START_POS_RST[SW-1:0];
			vel_x_q     <= START_VEL_RST[SW-1:0];
			vel_y_q     <= START_VEL_RST[SW-1:0];
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						b_q    <= uniform_b;
						x_q    <= xs_w;
						e_q    <= EW'(UNIFORM_BITS - 1);
						f_q    <= '0;
						i_q    <= '0;
						clip_q <= 1'b0;
						axis_q <= 1'b0;
						step_q <= OP_LOG;
						if (restart) begin
							pos_x_q <= start_px_q;
							pos_y_q <= start_py_q;
							vel_x_q <= start_vx_q;
							vel_y_q <= start_vy_q;
						end
						state_q <= S_NORM;
					end
				end
				// bring the leading one of u1 to bit 31
				S_NORM: begin
					if (x_q[32]) begin
						x_q     <= x_q >> 1;
						e_q     <= EW'(UNIFORM_BITS);
						state_q <= S_MUL;
					end else if (x_q[31]) begin
						state_q <= S_MUL;
					end else begin
						x_q <= x_q << 1;
						e_q <= e_q - EW'(1);
					end
				end
				S_MUL: begin
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (mul_done) begin
						unique case (step_q)
							// one fraction bit of log2 per squaring
							OP_LOG: begin
								if (mul_res[32]) begin
									f_q <= {f_q[LOG_BITS-2:0], 1'b1};
									x_q <= {1'b0, mul_res[32:1]};
								end else begin
									f_q <= {f_q[LOG_BITS-2:0], 1'b0};
									x_q <= mul_res[32:0];
								end
								i_q <= i_q + 5'd1;
								if (i_q == 5'(LOG_BITS - 1)) begin
									step_q <= OP_R2;
								end
								state_q <= S_MUL;
							end
							OP_R2: begin
								sqrt_v_q <= {mul_res[35:0], 28'd0};
								state_q  <= S_SQRT;
							end
							OP_ANG: begin
								z_q     <= mul_res[33:0];
								state_q <= S_CORDIC;
							end
							OP_G0: begin
								g0_q    <= mul_res;
								step_q  <= OP_G1;
								state_q <= S_MUL;
							end
							OP_G1: begin
								g1_q    <= mul_res;
								step_q  <= OP_DAMP;
								state_q <= S_MUL;
							end
							OP_DAMP: begin
								w_q     <= upd_a.v;
								clip_q  <= clip_q | mul_clip | upd_a.clip;
								step_q  <= OP_ACC;
								state_q <= S_MUL;
							end
							OP_ACC: begin
								w_q     <= mul_res;
								clip_q  <= clip_q | mul_clip;
								step_q  <= OP_DV;
								state_q <= S_MUL;
							end
							OP_DV: begin
								if (axis_q) begin
									vel_y_q <= upd_s.v;
								end else begin
									vel_x_q <= upd_s.v;
								end
								clip_q  <= clip_q | mul_clip | upd_a.clip | upd_s.clip;
								step_q  <= OP_POS;
								state_q <= S_MUL;
							end
							OP_POS: begin
								if (axis_q) begin
									pos_y_q <= upd_s.v;
									state_q <= S_DONE;
								end else begin
									pos_x_q <= upd_s.v;
									axis_q  <= 1'b1;
									step_q  <= OP_DAMP;
									state_q <= S_MUL;
								end
								clip_q <= clip_q | mul_clip | upd_a.clip | upd_s.clip;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SQRT: begin
					state_q <= S_SWAIT;
				end
				S_SWAIT: begin
					if (sqrt_done) begin
						r_q     <= sqrt_root;
						step_q  <= OP_ANG;
						state_q <= S_MUL;
					end
				end
				S_CORDIC: begin
					state_q <= S_CWAIT;
				end
				S_CWAIT: begin
					if (cor_done) begin
						c_q     <= cor_cos;
						s_q     <= cor_sin;
						step_q  <= OP_G0;
						state_q <= S_MUL;
					end
				end
				// hand the new state to the output register once it is free
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_px_q    <= pos_x_q;
						out_py_q    <= pos_y_q;
						out_vx_q    <= vel_x_q;
						out_vy_q    <= vel_y_q;
						out_sat_q   <= clip_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign pos_x     = out_px_q;
	assign pos_y     = out_py_q;
	assign vel_x     = out_vx_q;
	assign vel_y     = out_vy_q;
	assign saturated = out_sat_q;

endmodule

/* sv/lsp_mul.sv */
// shared multi-cycle multiplier: floor(a*b / 2^sh) saturated to 64 bits
// a signed 64 bit, b unsigned 32 bit; uses lsp_pkg

module lsp_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   a,
	input  logic [31:0]          b,
	input  lsp_pkg::lsp_sh_t     sh,
	output logic                 done,
	output logic signed [63:0]   res,
	output logic                 clip
);
	import lsp_pkg::*;

	typedef enum logic [2:0] {M_IDLE, M_LO, M_HI, M_NEG, M_SHIFT} mstate_t;

	mstate_t             state_q;
	logic                neg_q;
	logic [63:0]         mag_q;
	logic [31:0]         b_q;
	lsp_sh_t             sh_q;
	logic [63:0]         plo_q;
	logic [95:0]         prod_q;
	logic signed [96:0]  sgn_q;
	logic signed [63:0]  res_q;
	logic                clip_q;
	logic                done_q;
	logic [63:0]         pp;
	logic signed [96:0]  shifted;
	logic                fits;

	// one 32x32 multiplier, low half first then high half
	assign pp = 64'((state_q == M_LO) ? mag_q[31:0] : mag_q[63:32]) * 64'(b_q);

	// constant shift selection and 64 bit range check
	always_comb begin
		case (sh_q)
			SH_8:    shifted = sgn_q >>> 8;
			SH_16:   shifted = sgn_q >>> 16;
			SH_30:   shifted = sgn_q >>> 30;
			SH_31:   shifted = sgn_q >>> 31;
			SH_32:   shifted = sgn_q >>> 32;
			SH_42:   shifted = sgn_q >>> 42;
			default: shifted = sgn_q;
		endcase
		fits = (&shifted[96:63]) | ~(|shifted[96:63]);
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == M_SHIFT);
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						neg_q   <= a[63];
						mag_q   <= a[63] ? (64'd0 - 64'(a)) : 64'(a);
						b_q     <= b;
						sh_q    <= sh;
						state_q <= M_LO;
					end
				end
				M_LO: begin
					plo_q   <= pp;
					state_q <= M_HI;
				end
				M_HI: begin
					prod_q  <= 96'(plo_q) + {pp, 32'd0};
					state_q <= M_NEG;
				end
				M_NEG: begin
					sgn_q   <= neg_q ? (97'd0 - {1'b0, prod_q}) : {1'b0, prod_q};
					state_q <= M_SHIFT;
				end
				M_SHIFT: begin
					clip_q  <= ~fits;
					if (fits) begin
						res_q <= shifted[63:0];
					end else begin
						res_q <= neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
					end
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign clip = clip_q;

endmodule

/* sv/lsp_isqrt.sv */
// bit-serial integer square root of a 64 bit value, two bits a cycle
// no dependencies beyond its ports

module lsp_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] v,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	// one restoring step per cycle, 32 steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start && !busy_q) begin
				v_q    <= v;
				res_q  <= '0;
				bit_q  <= 64'd1 << 62;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

/* sv/lsp_cordic.sv */
// rotation mode cordic in Q.30, one micro-rotation a cycle, with quadrant fold
// uses lsp_pkg for the gain and the arctangent table

module lsp_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] z0,
	input  logic [1:0]         quad,
	output logic               done,
	output logic signed [33:0] cos_o,
	output logic signed [33:0] sin_o
);
	import lsp_pkg::*;

	logic signed [33:0] cx_q;
	logic signed [33:0] cy_q;
	logic signed [33:0] z_q;
	logic [1:0]         quad_q;
	logic [4:0]         i_q;
	logic               busy_q;
	logic               done_q;
	logic signed [33:0] cx_sh;
	logic signed [33:0] cy_sh;
	logic signed [33:0] atan_w;

	assign cx_sh  = cx_q >>> i_q;
	assign cy_sh  = cy_q >>> i_q;
	assign atan_w = signed'(34'(lsp_atan(i_q)));

	// micro-rotations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= busy_q && (i_q == 5'(CORDIC_STEPS - 1));
			if (start && !busy_q) begin
				cx_q   <= signed'(CORDIC_GAIN);
				cy_q   <= '0;
				z_q    <= z0;
				quad_q <= quad;
				i_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!z_q[33]) begin
					cx_q <= cx_q - cy_sh;
					cy_q <= cy_q + cx_sh;
					z_q  <= z_q - atan_w;
				end else begin
					cx_q <= cx_q + cy_sh;
					cy_q <= cy_q - cx_sh;
					z_q  <= z_q + atan_w;
				end
				i_q <= i_q + 5'd1;
				if (i_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// map the first quadrant result back to the full turn
	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_o = cx_q;
				sin_o = cy_q;
			end
			2'd1: begin
				cos_o = -cy_q;
				sin_o = cx_q;
			end
			2'd2: begin
				cos_o = -cx_q;
				sin_o = -cy_q;
			end
			default: begin
				cos_o = cy_q;
				sin_o = -cx_q;
			end
		endcase
	end

	assign done = done_q;

endmodule
